[rtl/integer_to_ascii_radix_defines.svh]
// Assertion macros for the integer_to_ascii_radix checker.
// No dependencies; include by bare file name.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ITOA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/itoa_pkg.sv]
// Shared constants, types and the digit-to-character function for the
// integer to ASCII converter. No dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int RADIX_BITS  = 6;
  localparam int CHAR_BITS   = 8;
  localparam int LENGTH_BITS = 6;
  localparam int TEXT_DEPTH  = VALUE_BITS + 1;
  localparam int ADDR_BITS   = $clog2(TEXT_DEPTH);
  localparam int CNT_BITS    = $clog2(TEXT_DEPTH + 1);
  localparam int STEP_BITS   = $clog2(VALUE_BITS);

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_BITS-1:0] DIGIT_MAX   = 6'd9;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_SIGN,
    S_RD,
    S_LOAD,
    S_OUT,
    S_TERM
  } state_t;

  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_status_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
    logic [CHAR_BITS-1:0] dx;
    dx = CHAR_BITS'(d);
    if (d > DIGIT_MAX) begin
      return dx - CHAR_BITS'(RADIX_DEC) + CHAR_ALPHA;
    end
    return dx + CHAR_ZERO;
  endfunction

endpackage

[rtl/itoa_divider.sv]
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [itoa_pkg::VALUE_BITS-1:0]     dividend,
  input  logic [itoa_pkg::RADIX_BITS-1:0]     divisor,
  output logic [itoa_pkg::VALUE_BITS-1:0]     quotient,
  output logic [itoa_pkg::RADIX_BITS-1:0]     remainder,
  output itoa_pkg::div_status_t               status
);
  import itoa_pkg::*;

  logic [VALUE_BITS-1:0] acc;
  logic [RADIX_BITS-1:0] rem;
  logic [STEP_BITS-1:0]  step;
  logic                  busy;
  logic                  done;
  logic [RADIX_BITS:0]   trial;
  logic [RADIX_BITS:0]   diff;
  logic                  fits;

  always_comb begin
    trial = {rem, acc[VALUE_BITS-1]};
    fits  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_BITS'(VALUE_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= dividend;
      rem  <= '0;
      step <= '0;
    end else if (busy) begin
      acc  <= {acc[VALUE_BITS-2:0], fits};
      rem  <= fits ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
      step <= step + 1'b1;
    end
  end

  assign quotient         = acc;
  assign remainder        = rem;
  assign status.done      = done;
  assign status.quot_zero = (acc == '0);

endmodule

[rtl/itoa_text_buf.sv]
// Character buffer: one write port, one registered read port.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_text_buf (
  input  logic                             clk,
  input  logic                             we,
  input  logic [itoa_pkg::ADDR_BITS-1:0]   waddr,
  input  logic [itoa_pkg::CHAR_BITS-1:0]   wdata,
  input  logic                             re,
  input  logic [itoa_pkg::ADDR_BITS-1:0]   raddr,
  output logic [itoa_pkg::CHAR_BITS-1:0]   rdata
);
  import itoa_pkg::*;

  logic [CHAR_BITS-1:0] mem [TEXT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/integer_to_ascii_radix.sv]
// Integer to ASCII text in a configurable radix; top level and sequencer.
// Sequence: per digit, start the divider, wait for the division and write the
// remainder's character; then per character read, load and present it, and
// finally the terminator. One transaction at a time; out_stall holds the output.
// Reset: synchronous, active high; radix returns to 10, sequencer to idle.
// Depends on itoa_pkg, itoa_divider and itoa_text_buf.
`timescale 1ns / 1ps

module integer_to_ascii_radix (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  radix_wr_en,
  input  logic [itoa_pkg::RADIX_BITS-1:0]       radix_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [itoa_pkg::CHAR_BITS-1:0]        char_code,
  output logic                                  last,
  output logic [itoa_pkg::LENGTH_BITS-1:0]      length
);
  import itoa_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [RADIX_BITS-1:0]  radix;
  logic [VALUE_BITS-1:0]  mag;
  logic                   neg;
  logic [CNT_BITS-1:0]    n;
  logic [CNT_BITS-1:0]    rd_ptr;
  logic [LENGTH_BITS-1:0] len;
  logic [CHAR_BITS-1:0]   char_q;

  logic                   div_start;
  logic [VALUE_BITS-1:0]  quotient;
  logic [RADIX_BITS-1:0]  remainder;
  div_status_t            div_status;
  logic                   mem_we;
  logic [CHAR_BITS-1:0]   mem_wdata;
  logic                   mem_re;
  logic [CHAR_BITS-1:0]   mem_rdata;
  logic                   in_neg;

  itoa_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (radix),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (div_status)
  );

  itoa_text_buf u_text_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (n[ADDR_BITS-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_ptr[ADDR_BITS-1:0]),
    .rdata (mem_rdata)
  );

  assign in_neg = (radix == RADIX_DEC) && value[VALUE_BITS-1];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (div_status.done) begin
          if (!div_status.quot_zero) begin
            state_next = S_START;
          end else if (neg) begin
            state_next = S_SIGN;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_SIGN:  state_next = S_RD;
      S_RD:    state_next = S_LOAD;
      S_LOAD:  state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_next = (rd_ptr == '0) ? S_TERM : S_RD;
        end
      end
      S_TERM:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    div_start = (state == S_START);
    mem_we    = (state == S_DIV && div_status.done) || (state == S_SIGN);
    mem_wdata = (state == S_SIGN) ? CHAR_MINUS : digit_char(remainder);
    mem_re    = (state == S_RD);
    out_valid = (state == S_OUT) || (state == S_TERM);
    last      = (state == S_TERM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      radix <= RADIX_RESET;
    end else begin
      state <= state_next;
      if (radix_wr_en) begin
        if (radix_wr_data < RADIX_MIN) begin
          radix <= RADIX_MIN;
        end else if (radix_wr_data > RADIX_MAX) begin
          radix <= RADIX_MAX;
        end else begin
          radix <= radix_wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          neg <= in_neg;
          mag <= in_neg ? $unsigned(-value) : $unsigned(value);
          n   <= '0;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          mag <= quotient;
          n   <= n + 1'b1;
          if (div_status.quot_zero && !neg) begin
            rd_ptr <= n;
            len    <= LENGTH_BITS'(n + CNT_BITS'(2));
          end
        end
      end
      S_SIGN: begin
        n      <= n + 1'b1;
        rd_ptr <= n;
        len    <= LENGTH_BITS'(n + CNT_BITS'(2));
      end
      S_LOAD: char_q <= mem_rdata;
      S_OUT: begin
        if (!out_stall) begin
          if (rd_ptr == '0) begin
            char_q <= CHAR_NUL;
          end else begin
            rd_ptr <= rd_ptr - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign char_code = char_q;
  assign length    = len;

endmodule

[rtl/itoa_checker.sv]
// Port-level checker for integer_to_ascii_radix, attached by bind.
// Depends on itoa_pkg and integer_to_ascii_radix_defines.svh.
`timescale 1ns / 1ps
`include "integer_to_ascii_radix_defines.svh"

module itoa_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [itoa_pkg::CHAR_BITS-1:0]        char_code,
  input logic                                  last,
  input logic [itoa_pkg::LENGTH_BITS-1:0]      length
);
  import itoa_pkg::*;

  `ITOA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(char_code) && $stable(last) && $stable(length), "stalled result changed")
  `ITOA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall && !out_valid, "not busy after input transaction")
  `ITOA_ASSERT_SAME(a_term_nul, clk, rst, out_valid && last, char_code == CHAR_NUL, "terminator is not zero")
  `ITOA_ASSERT_SAME(a_text_nonzero, clk, rst, out_valid && !last, char_code != CHAR_NUL, "zero byte inside text")

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .char_code (char_code),
  .last      (last),
  .length    (length)
);

[tb/sv/integer_to_ascii_radix_test.sv]
// Self-checking testbench for integer_to_ascii_radix: directed table, then random
// values across radix settings, checked against table text or an in-bench predictor.
// Depends on itoa_pkg and the integer_to_ascii_radix RTL.
`timescale 1ns / 1ps

module integer_to_ascii_radix_test;
  import itoa_pkg::*;

  typedef struct packed {
    logic [CHAR_BITS-1:0]   code;
    logic                   last;
    logic [LENGTH_BITS-1:0] len;
  } text_char_t;

  typedef struct {
    logic                   write_radix;
    logic [RADIX_BITS-1:0]  radix_data;
    logic [VALUE_BITS-1:0]  value;
    string                  text;
  } text_case_t;

  localparam int CASES = 22;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 30;
  localparam int HOLD_CYCLES = 2500;
  localparam int HOLD_AFTER = 600;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic radix_wr_en = 1'b0;
  logic [RADIX_BITS-1:0] radix_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CHAR_BITS-1:0] char_code;
  logic last;
  logic [LENGTH_BITS-1:0] length;

  text_char_t expected_chars[$];
  logic [RADIX_BITS-1:0] radix_now = RADIX_RESET;
  int mismatches = 0;
  int chars_received = 0;

  // Empty text: take the expectation from the predictor.
  text_case_t text_cases[CASES] = '{
    '{1'b0, 6'd0,  32'h0000_0000, "0"},
    '{1'b0, 6'd0,  32'h7FFF_FFFF, "2147483647"},
    '{1'b0, 6'd0,  32'h8000_0000, "-2147483648"},
    '{1'b0, 6'd0,  32'hFFFF_FFFF, "-1"},
    '{1'b0, 6'd0,  32'h0000_0001, "1"},
    '{1'b1, 6'd0,  32'hFFFF_FFFF, ""},
    '{1'b0, 6'd0,  32'h8000_0000, ""},
    '{1'b0, 6'd0,  32'h0000_0000, "0"},
    '{1'b1, 6'd1,  32'h0000_0005, "101"},
    '{1'b1, 6'd63, 32'h0000_0023, "Z"},
    '{1'b0, 6'd0,  32'hFFFF_FFFF, ""},
    '{1'b1, 6'd37, 32'h0000_0024, "10"},
    '{1'b1, 6'd36, 32'h7FFF_FFFF, ""},
    '{1'b1, 6'd16, 32'hFFFF_FFFF, "FFFFFFFF"},
    '{1'b0, 6'd0,  32'h7FFF_FFFF, "7FFFFFFF"},
    '{1'b0, 6'd0,  32'h8000_0000, "80000000"},
    '{1'b0, 6'd0,  32'h00AB_CDEF, "ABCDEF"},
    '{1'b1, 6'd8,  32'hFFFF_FFFF, "37777777777"},
    '{1'b1, 6'd3,  32'hFFFF_FFFF, ""},
    '{1'b1, 6'd10, 32'hFFFF_FF85, "-123"},
    '{1'b0, 6'd0,  32'h0000_0009, "9"},
    '{1'b0, 6'd0,  32'h0000_000A, "10"}
  };

  integer_to_ascii_radix DUT (
    .clk(clk),
    .rst(rst),
    .radix_wr_en(radix_wr_en),
    .radix_wr_data(radix_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .char_code(char_code),
    .last(last),
    .length(length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void predict_text(logic [VALUE_BITS-1:0] v);
    logic [CHAR_BITS-1:0] rev[$];
    logic [VALUE_BITS-1:0] x;
    logic [VALUE_BITS-1:0] d;
    logic neg;
    logic [LENGTH_BITS-1:0] total;
    x = v;
    neg = (radix_now == RADIX_DEC) && x[VALUE_BITS-1];
    if (neg) x = -x;
    do begin
      d = x % radix_now;
      rev.push_back(d > DIGIT_MAX ? CHAR_BITS'(d) - CHAR_BITS'(RADIX_DEC) + CHAR_ALPHA
                                  : CHAR_BITS'(d) + CHAR_ZERO);
      x = x / radix_now;
    end while (x != 0);
    if (neg) rev.push_back(CHAR_MINUS);
    total = LENGTH_BITS'(rev.size() + 1);
    for (int k = rev.size() - 1; k >= 0; k--) expected_chars.push_back('{rev[k], 1'b0, total});
    expected_chars.push_back('{CHAR_NUL, 1'b1, total});
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [63:0] p;
    int k;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 40);
      2: return -VALUE_BITS'($urandom_range(1, 40));
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      4: begin
        p = 64'd1;
        k = $urandom_range(0, 31);
        repeat (k) if (p * radix_now < 64'h1_0000_0000) p = p * radix_now;
        return VALUE_BITS'(p - $urandom_range(0, 1));
      end
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic set_radix(logic [RADIX_BITS-1:0] data);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    radix_wr_en <= 1'b1;
    radix_wr_data <= data;
    @(posedge clk);
    radix_wr_en <= 1'b0;
    radix_now = data < RADIX_MIN ? RADIX_MIN : (data > RADIX_MAX ? RADIX_MAX : data);
  endtask

  task automatic push_value(logic [VALUE_BITS-1:0] v, string text, int gap);
    logic [LENGTH_BITS-1:0] total;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_stall);
    if (text.len() == 0) begin
      predict_text(v);
    end else begin
      total = LENGTH_BITS'(text.len() + 1);
      for (int i = 0; i < text.len(); i++) expected_chars.push_back('{text[i], 1'b0, total});
      expected_chars.push_back('{CHAR_NUL, 1'b1, total});
    end
  endtask

  initial begin
    text_char_t want;
    int idle_left;
    int hold_left;
    logic hold_done;
    logic quiet;
    idle_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          chars_received++;
          if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h last %0b length %0d",
                                      char_code, last, length));
          end else begin
            want = expected_chars.pop_front();
            if (char_code !== want.code || last !== want.last || length !== want.len)
              report_mismatch($sformatf("got 0x%02h/%0b/%0d, want 0x%02h/%0b/%0d",
                                        char_code, last, length, want.code, want.last,
                                        want.len));
          end
        end
        if ($urandom_range(0, 299) == 0) quiet = !quiet;
        if (hold_left > 0) begin
          out_stall <= 1'b1;
          hold_left--;
        end else if (!hold_done && chars_received >= HOLD_AFTER) begin
          out_stall <= 1'b1;
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end else if (idle_left > 0) begin
          out_stall <= 1'b1;
          idle_left--;
        end else begin
          out_stall <= 1'b0;
          idle_left = quiet ? 0 : pick_gap();
        end
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("integer_to_ascii_radix test failed");
    $finish;
  end

  initial begin
    logic [RADIX_BITS-1:0] data;
    logic quiet;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < CASES; i++) begin
      if (text_cases[i].write_radix) set_radix(text_cases[i].radix_data);
      push_value(text_cases[i].value, text_cases[i].text, pick_gap());
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) data = RADIX_MIN;
      else if (ph == 1) data = RADIX_MAX;
      else if ($urandom_range(0, 4) == 0) data = RADIX_BITS'($urandom_range(0, 63));
      else data = RADIX_BITS'($urandom_range(2, 36));
      set_radix(data);
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) push_value(random_value(), "", quiet ? 0 : pick_gap());
    end
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("integer_to_ascii_radix test passed");
    end else begin
      $display("integer_to_ascii_radix test failed");
    end
    $finish;
  end

endmodule
